[src/rrv_pkg.sv]
// rrv_pkg: shared types and helpers of the ray refraction pipeline.
// No dependencies.
package rrv_pkg;

  // Control handed to the root pipeline: input valid and an advance shared by all stages.
  typedef struct packed {
    logic valid;
    logic adv;
  } pipe_ctl_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

[src/rrv_sqrt_pipe.sv]
// rrv_sqrt_pipe: floor square root, one result bit per register stage,
// with a sideband word carried alongside. Depends on rrv_pkg.
module rrv_sqrt_pipe import rrv_pkg::*; #(
  parameter int RAD_W  = 64,
  parameter int SIDE_W = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pipe_ctl_t            ctl,
  input  logic [RAD_W-1:0]     rad,
  input  logic [SIDE_W-1:0]    side_in,
  output logic                 valid,
  output logic [RAD_W/2-1:0]   root,
  output logic [SIDE_W-1:0]    side_out
);

  localparam int STEPS = RAD_W / 2;
  localparam int REM_W = STEPS + 2;

  logic [STEPS-1:0]  vld_r;
  logic [RAD_W-1:0]  rad_r  [STEPS];
  logic [STEPS-1:0]  res_r  [STEPS];
  logic [REM_W-1:0]  rem_r  [STEPS];
  logic [SIDE_W-1:0] side_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic              vld_s;
    logic [RAD_W-1:0]  rad_s;
    logic [STEPS-1:0]  res_s;
    logic [REM_W-1:0]  rem_s;
    logic [SIDE_W-1:0] side_s;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign vld_s  = ctl.valid;
      assign rad_s  = rad;
      assign res_s  = '0;
      assign rem_s  = '0;
      assign side_s = side_in;
    end else begin : g_next
      assign vld_s  = vld_r[k-1];
      assign rad_s  = rad_r[k-1];
      assign res_s  = res_r[k-1];
      assign rem_s  = rem_r[k-1];
      assign side_s = side_r[k-1];
    end

    // bring down the next two radicand bits and try the next root bit
    assign rem_sh = {rem_s[REM_W-3:0], rad_s[RAD_W-1 -: 2]};
    assign trial  = {res_s, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl.adv) begin
        vld_r[k] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        rad_r[k]  <= rad_s << 2;
        side_r[k] <= side_s;
        if (rem_sh >= trial) begin
          rem_r[k] <= rem_sh - trial;
          res_r[k] <= {res_s[STEPS-2:0], 1'b1};
        end else begin
          rem_r[k] <= rem_sh;
          res_r[k] <= {res_s[STEPS-2:0], 1'b0};
        end
      end
    end
  end

  assign valid    = vld_r[STEPS-1];
  assign root     = res_r[STEPS-1];
  assign side_out = side_r[STEPS-1];

endmodule

[src/ray_refraction_vector.sv]
// ray_refraction_vector: Snell refraction of a direction about a normal,
// signed fixed point, fully pipelined. Depends on rrv_pkg, rrv_sqrt_pipe.
//
//  channel  | direction | words                                    | handshake
//  ---------+-----------+------------------------------------------+--------------
//  in_      | input     | dir_x/y/z, norm_x/y/z, index_ratio       | valid / stall
//  out_     | output    | x/y/z, clipped                           | valid / stall
//
// One word is accepted per cycle while the output is not stalled. The radicand
// width of the root stage is 64 at default widths.
// The root takes one bit per stage and sets most of the pipeline depth.
// rst_n (synchronous) clears the valid bits only; payload registers hold junk.
// A stalled output word freezes every stage at once; in_stall follows it.
module ray_refraction_vector import rrv_pkg::*; #(
  parameter int COMP_WIDTH = 16,
  parameter int FRAC_BITS  = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COMP_WIDTH-1:0] in_dir_x,
  input  logic signed [COMP_WIDTH-1:0] in_dir_y,
  input  logic signed [COMP_WIDTH-1:0] in_dir_z,
  input  logic signed [COMP_WIDTH-1:0] in_norm_x,
  input  logic signed [COMP_WIDTH-1:0] in_norm_y,
  input  logic signed [COMP_WIDTH-1:0] in_norm_z,
  input  logic        [COMP_WIDTH-2:0] in_index_ratio,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COMP_WIDTH-1:0] out_x,
  output logic signed [COMP_WIDTH-1:0] out_y,
  output logic signed [COMP_WIDTH-1:0] out_z,
  output logic                         out_clipped
);

  localparam int W    = COMP_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int PDW  = 2 * W;                       // d*n
  localparam int ACCW = 2 * W + 2;                   // dot sum
  localparam int NAW  = ACCW + 1;                    // negated dot
  localparam int XW   = imax(NAW, F + 2);            // cap compare
  localparam int COSW = imax(2 * W - F + 1, F + 2);  // capped cosine
  localparam int CNW  = COSW + W;                    // cos*n
  localparam int TW   = imax(CNW - F, W) + 1;        // d + cos*n
  localparam int RTP  = TW + W;                      // ratio*t
  localparam int PW   = imax(RTP - F, 2);            // perpendicular part
  localparam int SQW  = 2 * PW;                      // perp^2
  localparam int L2W  = SQW + 2;                     // |perp|^2
  localparam int L2SW = imax(L2W - F, F + 2);
  localparam int DFW  = imax(L2SW, F + 2) + 1;       // 1 - |perp|^2
  localparam int RADN = DFW + F;
  localparam int RW   = RADN + (RADN % 2);           // radicand, even
  localparam int RTW  = RW / 2;                      // root
  localparam int RNW  = RTW + 1 + W;                 // root*n
  localparam int PARW = imax(RNW - F, 1) + 1;        // parallel part
  localparam int SW   = imax(PW, PARW) + 1;          // final sum
  localparam int SIDE = 3 * PW + 3 * W;

  // One enable for the whole pipe: advance unless the output word is held.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic [8:1] v_r;
  logic       v9_r;
  logic       vq;

  // stage registers
  logic signed [W-1:0]    d1_r [3], n1_r [3], d2_r [3], n2_r [3], d3_r [3], n3_r [3];
  logic signed [W-1:0]    n4_r [3], n5_r [3], n6_r [3], n7_r [3];
  logic        [W-2:0]    rat1_r, rat2_r, rat3_r, rat4_r;
  logic signed [PDW-1:0]  p1_r [3];
  logic signed [COSW-1:0] cos2_r;
  logic signed [CNW-1:0]  cn3_r [3];
  logic signed [TW-1:0]   t4_r [3];
  logic signed [RTP-1:0]  rt5_r [3];
  logic signed [PW-1:0]   perp6_r [3], perp7_r [3], perp9_r [3];
  logic signed [SQW-1:0]  sq7_r [3];
  logic        [RW-1:0]   rad8_r;
  logic        [SIDE-1:0] side8_r;
  logic signed [RNW-1:0]  rn9_r [3];
  logic                   out_valid_r;
  logic signed [W-1:0]    out_r [3];
  logic                   clip_r;

  // combinational nodes
  logic signed [W-1:0]    d_in [3], n_in [3];
  logic signed [ACCW-1:0] acc;
  logic signed [XW-1:0]   negx, shx, one_x;
  logic signed [L2W-1:0]  l2;
  logic signed [DFW-1:0]  diff, dmag;
  logic        [RTW-1:0]  root;
  logic        [SIDE-1:0] side_q;
  logic signed [PW-1:0]   perp_q [3];
  logic signed [W-1:0]    n_q [3];
  logic signed [W-1:0]    sat_nxt [3];
  logic                   clip_nxt;

  assign d_in = '{in_dir_x, in_dir_y, in_dir_z};
  assign n_in = '{in_norm_x, in_norm_y, in_norm_z};

  // valid bits advance with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      v9_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[7:1], in_valid};
      v9_r        <= vq;
      out_valid_r <= v9_r;
    end
  end

  // cosine: floor of minus the dot product, capped at one
  always_comb begin
    acc   = ACCW'(p1_r[0]) + ACCW'(p1_r[1]) + ACCW'(p1_r[2]);
    negx  = -(XW'(acc));
    shx   = negx >>> F;
    one_x = XW'(1) <<< F;
    if (shx > one_x) begin
      shx = one_x;
    end
  end

  // radicand: |1 - |perp|^2| with F fraction bits added for the root
  always_comb begin
    l2   = L2W'(sq7_r[0]) + L2W'(sq7_r[1]) + L2W'(sq7_r[2]);
    diff = (DFW'(1) <<< F) - DFW'(L2SW'(l2 >>> F));
    dmag = (diff < 0) ? -diff : diff;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        // stage 1: d.n products
        p1_r[i]    <= PDW'(d_in[i]) * PDW'(n_in[i]);
        d1_r[i]    <= d_in[i];
        n1_r[i]    <= n_in[i];
        // stage 2: cosine
        d2_r[i]    <= d1_r[i];
        n2_r[i]    <= n1_r[i];
        // stage 3: cos*n
        cn3_r[i]   <= CNW'(cos2_r) * CNW'(n2_r[i]);
        d3_r[i]    <= d2_r[i];
        n3_r[i]    <= n2_r[i];
        // stage 4: d + cos*n
        t4_r[i]    <= TW'(d3_r[i]) + TW'(cn3_r[i] >>> F);
        n4_r[i]    <= n3_r[i];
        // stage 5: ratio*t
        rt5_r[i]   <= RTP'($signed({1'b0, rat4_r})) * RTP'(t4_r[i]);
        n5_r[i]    <= n4_r[i];
        // stage 6: perpendicular part
        perp6_r[i] <= PW'(rt5_r[i] >>> F);
        n6_r[i]    <= n5_r[i];
        // stage 7: squares
        sq7_r[i]   <= SQW'(perp6_r[i]) * SQW'(perp6_r[i]);
        perp7_r[i] <= perp6_r[i];
        n7_r[i]    <= n6_r[i];
      end
      rat1_r  <= in_index_ratio;
      rat2_r  <= rat1_r;
      rat3_r  <= rat2_r;
      rat4_r  <= rat3_r;
      cos2_r  <= COSW'(shx);
      // stage 8: radicand, perp and n ride along as sideband
      rad8_r  <= RW'($unsigned(dmag)) << F;
      side8_r <= {perp7_r[0], perp7_r[1], perp7_r[2], n7_r[0], n7_r[1], n7_r[2]};
    end
  end

  pipe_ctl_t sq_ctl;
  assign sq_ctl = '{valid: v_r[8], adv: adv};

  rrv_sqrt_pipe #(
    .RAD_W  (RW),
    .SIDE_W (SIDE)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sq_ctl),
    .rad      (rad8_r),
    .side_in  (side8_r),
    .valid    (vq),
    .root     (root),
    .side_out (side_q)
  );

  assign {perp_q[0], perp_q[1], perp_q[2], n_q[0], n_q[1], n_q[2]} = side_q;

  // final stage: perp - floor(root*n), saturate to the component range
  always_comb begin
    logic signed [SW-1:0] sum;
    clip_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum = SW'(perp9_r[i]) - SW'(PARW'(rn9_r[i] >>> F));
      if (sum > ((SW'(1) <<< (W - 1)) - SW'(1))) begin
        sat_nxt[i] = {1'b0, {(W - 1){1'b1}}};
        clip_nxt   = 1'b1;
      end else if (sum < -(SW'(1) <<< (W - 1))) begin
        sat_nxt[i] = {1'b1, {(W - 1){1'b0}}};
        clip_nxt   = 1'b1;
      end else begin
        sat_nxt[i] = W'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        rn9_r[i]   <= RNW'($signed({1'b0, root})) * RNW'(n_q[i]);
        perp9_r[i] <= perp_q[i];
        out_r[i]   <= sat_nxt[i];
      end
      clip_r <= clip_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_x       = out_r[0];
  assign out_y       = out_r[1];
  assign out_z       = out_r[2];
  assign out_clipped = clip_r;

endmodule

[tb/ray_refraction_vector_chk.sv]
// ray_refraction_vector_chk: watches both channels of the refraction block,
// predicts each refracted direction and compares it. Depends on nothing but the ports.
module ray_refraction_vector_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  input  logic signed [15:0] in_norm_x,
  input  logic signed [15:0] in_norm_y,
  input  logic signed [15:0] in_norm_z,
  input  logic        [14:0] in_index_ratio,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_x,
  input  logic signed [15:0] out_y,
  input  logic signed [15:0] out_z,
  input  logic               out_clipped,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               clipped;
  } refr_t;

  refr_t expected_rays[$];

  // Products stay far inside 64 bits at these widths, so no internal saturation.
  function automatic longint floor_q12(longint a);
    return a >>> 12;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic refr_t refract(longint d[3], longint n[3], longint ratio);
    longint acc, cosv, len2, diff, root, t, r;
    longint perp[3];
    refr_t res;
    logic signed [15:0] c[3];
    acc = 0;
    for (int i = 0; i < 3; i++) acc += d[i] * n[i];
    cosv = floor_q12(-acc);
    if (cosv > 4096) cosv = 4096;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      t = d[i] + floor_q12(cosv * n[i]);
      perp[i] = floor_q12(ratio * t);
      len2 += perp[i] * perp[i];
    end
    len2 = floor_q12(len2);
    diff = 4096 - len2;
    if (diff < 0) diff = -diff;
    root = int_sqrt(diff * 4096);
    res.clipped = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r = perp[i] - floor_q12(root * n[i]);
      if (r > 32767) begin r = 32767; res.clipped = 1'b1; end
      if (r < -32768) begin r = -32768; res.clipped = 1'b1; end
      c[i] = r[15:0];
    end
    res.x = c[0];
    res.y = c[1];
    res.z = c[2];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    longint d[3], n[3];
    refr_t want;
    if (rst_n && in_valid && !in_stall) begin
      d[0] = in_dir_x;  d[1] = in_dir_y;  d[2] = in_dir_z;
      n[0] = in_norm_x; n[1] = in_norm_y; n[2] = in_norm_z;
      expected_rays.push_back(refract(d, n, longint'(in_index_ratio)));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rays.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        want = expected_rays.pop_front();
        if (out_x !== want.x) report_mismatch("x", out_x, want.x);
        if (out_y !== want.y) report_mismatch("y", out_y, want.y);
        if (out_z !== want.z) report_mismatch("z", out_z, want.z);
        if (out_clipped !== want.clipped)
          report_mismatch("clipped", out_clipped, want.clipped);
      end
    end
    pending = expected_rays.size();
  end
endmodule

[tb/ray_refraction_vector_tb.sv]
// ray_refraction_vector_tb: stimulus and verdict for the refraction block.
// Depends on ray_refraction_vector and ray_refraction_vector_chk.
module ray_refraction_vector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [15:0] in_norm_x = '0, in_norm_y = '0, in_norm_z = '0;
  logic [14:0] in_index_ratio = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_x, out_y, out_z;
  logic out_clipped;
  int fail_count, pending;
  int cycle_count = 0;
  bit stim_done = 1'b0;
  bit calm_rx = 1'b0;     // no receiver idling in this stretch
  int hold_rx = 0;        // cycles of forced receiver hold-off left

  localparam int LIMIT = 200000;

  ray_refraction_vector dut (.*);

  ray_refraction_vector_chk chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count cycles and kill a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: stall at random about 21 percent of the time, except in calm stretches;
  // a forced hold-off keeps stall high and counts itself down.
  always @(posedge clk) begin
    if (hold_rx > 0) begin
      out_stall <= 1'b1;
      hold_rx <= hold_rx - 1;
    end else begin
      out_stall <= calm_rx ? 1'b0 : ($urandom_range(99) < 21);
    end
  end

  function automatic logic signed [15:0] unit_comp();
    // Mostly near-unit components, sometimes anything at all.
    if ($urandom_range(9) == 0) return 16'($urandom);
    return $signed(16'($urandom_range(8192))) - 16'sd4096;
  endfunction

  // Offer one word and hold it until accepted; sender idles at random when may_idle is set.
  task automatic send_word(logic signed [15:0] dx, dy, dz, nx, ny, nz,
                           logic [14:0] ratio, bit may_idle);
    while (may_idle && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_dir_x <= dx; in_dir_y <= dy; in_dir_z <= dz;
    in_norm_x <= nx; in_norm_y <= ny; in_norm_z <= nz;
    in_index_ratio <= ratio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] v[6];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: head-on, grazing, total internal reflection, extremes.
    send_word(16'sd0, 16'sd0, -16'sd4096, 16'sd0, 16'sd0, 16'sd4096, 15'd4096, 1'b0);
    send_word(16'sd0, 16'sd0, -16'sd4096, 16'sd0, 16'sd0, 16'sd4096, 15'd3072, 1'b0);
    send_word(16'sd2896, 16'sd0, -16'sd2896, 16'sd0, 16'sd0, 16'sd4096, 15'd6144, 1'b0);
    send_word(16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4096, 15'd4096, 1'b0);
    // Cosine above 1.0 gets capped.
    send_word(16'sd0, 16'sd0, -16'sd8192, 16'sd0, 16'sd0, 16'sd8192, 15'd4096, 1'b0);
    // Negative cosine: direction along the normal.
    send_word(16'sd0, 16'sd2896, 16'sd2896, 16'sd0, 16'sd0, 16'sd4096, 15'd5000, 1'b0);
    send_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              15'h7fff, 1'b0);
    send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              15'h7fff, 1'b0);
    send_word(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
              15'd0, 1'b0);
    send_word(16'sh7fff, 16'sh8000, 16'sh0001, 16'sh8000, 16'sh7fff, 16'shffff,
              15'd1, 1'b0);
    send_word('0, '0, '0, '0, '0, '0, 15'd0, 1'b0);
    send_word(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
              15'h5555, 1'b0);
    send_word(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555,
              15'h2aaa, 1'b0);

    // Random part, with a calm stretch, a long receiver hold-off and a drain to empty.
    for (int k = 0; k < 400; k++) begin
      calm_rx <= (k >= 100 && k < 160);
      if (k == 200) hold_rx <= 300;
      if (k == 300) begin
        go_idle();
        while (pending != 0) @(posedge clk);
      end
      foreach (v[i]) v[i] = unit_comp();
      send_word(v[0], v[1], v[2], v[3], v[4], v[5],
                ($urandom_range(7) == 0) ? 15'($urandom) : 15'($urandom_range(8192)),
                !(k >= 100 && k < 160));
    end
    go_idle();
    stim_done = 1'b1;
  end

  // Drain, allow the pipeline latency, then give the verdict.
  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[filelist.f]
src/rrv_pkg.sv
src/rrv_sqrt_pipe.sv
src/ray_refraction_vector.sv
tb/ray_refraction_vector_chk.sv
tb/ray_refraction_vector_tb.sv
